FILE: rtl/core/abds_pkg.sv
package abds_pkg;

  // Sizes fixed by the field formats
  localparam int unsigned PosW     = 4;
  localparam int unsigned AltDmW   = 20;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned EntryAltW = 15;
  localparam int unsigned LayerIdW = 8;
  localparam int unsigned CountW   = 5;
  localparam int unsigned HoldW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam int unsigned MaxLayersDefault = 16;
  localparam logic [HoldW-1:0] HoldReset = 8'd20;

  typedef enum logic [1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_STEP    = 2'd1,
    FUNC_SET_POS = 2'd2,
    FUNC_WRITE   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AUTO_EN   = 2'd0,
    CFG_LAYER_CNT = 2'd1,
    CFG_HOLD      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    func_e                       func;
    logic signed [AltDmW-1:0]    gps_alt_dm;
    logic signed [AltDmW-1:0]    baro_alt_dm;
    logic [TimeW-1:0]            now_seconds;
    logic                        now_valid;
    logic [PosW-1:0]             position;
    logic [EntryAltW-1:0]        entry_altitude_m;
    logic [LayerIdW-1:0]         entry_layer_id;
  } in_t;

  typedef struct packed {
    logic [PosW-1:0]     new_position;
    logic [LayerIdW-1:0] switched_layer_id;
  } out_t;

endpackage

FILE: rtl/core/altitude_band_dwell_selector.sv
// A result is loaded into the output register when its item leaves the input register
// (input register, then one pass of band lookup and state update).
// Throughput: one item per cycle; the output register and input register decouple
// the two sides, so only a held result stalls the input.
// Reset: control state, configuration and the output side clear at once; the layer
// table holds no reset and is undefined until its entries are written.
module altitude_band_dwell_selector #(
  parameter int unsigned MAX_LAYERS = abds_pkg::MaxLayersDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [abds_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [abds_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  abds_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output abds_pkg::out_t                    out_data_o
);

  localparam int unsigned BW = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned NW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned XW = (NW > abds_pkg::CountW) ? NW : abds_pkg::CountW;
  localparam int unsigned CW = (BW > abds_pkg::PosW) ? BW : abds_pkg::PosW;
  localparam int unsigned ThrW = abds_pkg::AltDmW + 1;
  localparam int unsigned SumW = abds_pkg::EntryAltW + 1;

  // Configuration
  logic                            auto_en_q;
  logic [abds_pkg::CountW-1:0]     layer_cnt_q;
  logic [abds_pkg::HoldW-1:0]      hold_q;

  // Input register
  logic           s1_vld_q, s1_vld_d;
  abds_pkg::in_t  s1_q;
  logic           s1_adv;
  logic           in_fire;

  // Layer table
  logic [abds_pkg::EntryAltW-1:0] alt_mem_q [MAX_LAYERS];
  logic [abds_pkg::LayerIdW-1:0]  id_mem_q  [MAX_LAYERS];
  logic                           tbl_we;
  logic [BW-1:0]                  tbl_idx;
  logic                           pos_in_tbl;

  // Band state
  logic [abds_pkg::PosW-1:0]  cur_q, cur_d;
  logic                       pend_q, pend_d;
  logic [BW-1:0]              pend_pos_q, pend_pos_d;
  logic [abds_pkg::TimeW-1:0] cross_t_q, cross_t_d;
  logic                       cross_vld_q, cross_vld_d;
  logic                       ovr_q, ovr_d;
  logic                       pin_vld_q, pin_vld_d;
  logic [BW-1:0]              pin_q, pin_d;
  logic                       last_vld_q, last_vld_d;
  logic [BW-1:0]              last_q, last_d;

  // Output register
  logic            out_vld_q;
  abds_pkg::out_t  out_q;
  logic            res_fire;

  // Lookup
  logic                       gps_neg;
  logic                       alt_ok;
  logic [abds_pkg::AltDmW-2:0] alt;
  logic [ThrW-1:0]            alt_x2;
  logic [MAX_LAYERS-2:0]      hit;
  logic [XW-1:0]              cnt_x;
  logic [XW-1:0]              n_eff;
  logic [BW-1:0]              target;
  logic [abds_pkg::TimeW-1:0] elapsed;
  logic                       do_sample;

  // Handshake: the input register moves on when the output slot is free or freeing
  assign s1_adv     = s1_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_data_i;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en_q   <= 1'b0;
      layer_cnt_q <= '0;
      hold_q      <= abds_pkg::HoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abds_pkg::CFG_AUTO_EN:   auto_en_q   <= cfg_wdata_i[0];
        abds_pkg::CFG_LAYER_CNT: layer_cnt_q <= cfg_wdata_i[abds_pkg::CountW-1:0];
        abds_pkg::CFG_HOLD:      hold_q      <= cfg_wdata_i[abds_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Altitude source: GPS when non-negative, else baro
  assign gps_neg = s1_q.gps_alt_dm[abds_pkg::AltDmW-1];
  assign alt     = gps_neg ? s1_q.baro_alt_dm[abds_pkg::AltDmW-2:0]
                           : s1_q.gps_alt_dm[abds_pkg::AltDmW-2:0];
  assign alt_ok  = !gps_neg || !s1_q.baro_alt_dm[abds_pkg::AltDmW-1];
  assign alt_x2  = {1'b0, alt, 1'b0};

  // Saturate the layer count to the table depth
  assign cnt_x = XW'(layer_cnt_q);
  assign n_eff = (cnt_x > XW'(MAX_LAYERS)) ? XW'(MAX_LAYERS) : cnt_x;

  // Midpoint thresholds: 2*alt >= 10*(alt[i]+alt[i+1])
  for (genvar i = 0; i < MAX_LAYERS - 1; i++) begin : g_thr
    logic [SumW-1:0] sum;
    logic [ThrW-1:0] thr;
    assign sum    = SumW'(alt_mem_q[i]) + SumW'(alt_mem_q[i+1]);
    assign thr    = ThrW'({sum, 3'b000}) + ThrW'({sum, 1'b0});
    assign hit[i] = (XW'(i + 1) < n_eff) && (alt_x2 >= thr);
  end

  always_comb begin
    target = '0;
    for (int i = 0; i < MAX_LAYERS - 1; i++) begin
      if (hit[i]) begin
        target = BW'(i + 1);
      end
    end
  end

  assign elapsed   = s1_q.now_seconds - cross_t_q;
  assign do_sample = (s1_q.func == abds_pkg::FUNC_SAMPLE) && auto_en_q && alt_ok &&
                     (n_eff >= XW'(2));

  assign pos_in_tbl = (32'(s1_q.position) < MAX_LAYERS);
  assign tbl_idx    = BW'(s1_q.position);
  assign tbl_we     = s1_adv && (s1_q.func == abds_pkg::FUNC_WRITE) && pos_in_tbl;

  always_comb begin
    cur_d       = cur_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;
    cross_t_d   = cross_t_q;
    cross_vld_d = cross_vld_q;
    ovr_d       = ovr_q;
    pin_vld_d   = pin_vld_q;
    pin_d       = pin_q;
    last_vld_d  = last_vld_q;
    last_d      = last_q;
    res_fire    = 1'b0;
    case (s1_q.func)
      abds_pkg::FUNC_SAMPLE: begin
        if (do_sample) begin
          last_vld_d = 1'b1;
          last_d     = target;
          if (ovr_q && !pin_vld_q) begin
            // bind a pin taken before any band was known
            pin_vld_d = 1'b1;
            pin_d     = target;
          end else if (ovr_q && (target == pin_q)) begin
            // hold the pinned band
          end else begin
            ovr_d = 1'b0;
            if (CW'(target) == CW'(cur_q)) begin
              pend_d = 1'b0;
            end else if (!pend_q || (pend_pos_q != target)) begin
              pend_d      = 1'b1;
              pend_pos_d  = target;
              cross_t_d   = s1_q.now_seconds;
              cross_vld_d = s1_q.now_valid;
            end else if (s1_q.now_valid && cross_vld_q &&
                         (elapsed[abds_pkg::TimeW-1] ||
                          (elapsed < abds_pkg::TimeW'(hold_q)))) begin
              // keep waiting for the dwell time
            end else begin
              pend_d   = 1'b0;
              cur_d    = abds_pkg::PosW'(target);
              res_fire = 1'b1;
            end
          end
        end
      end
      abds_pkg::FUNC_STEP: begin
        ovr_d     = 1'b1;
        pin_vld_d = last_vld_q;
        pin_d     = last_q;
        pend_d    = 1'b0;
      end
      abds_pkg::FUNC_SET_POS: begin
        cur_d  = s1_q.position;
        pend_d = 1'b0;
      end
      default: begin
        if (pos_in_tbl) begin
          pend_d     = 1'b0;
          ovr_d      = 1'b0;
          pin_vld_d  = 1'b0;
          last_vld_d = 1'b0;
        end
      end
    endcase
    if (!s1_adv) begin
      res_fire = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      pend_q      <= 1'b0;
      pend_pos_q  <= '0;
      cross_t_q   <= '0;
      cross_vld_q <= 1'b0;
      ovr_q       <= 1'b0;
      pin_vld_q   <= 1'b0;
      pin_q       <= '0;
      last_vld_q  <= 1'b0;
      last_q      <= '0;
    end else if (s1_adv) begin
      cur_q       <= cur_d;
      pend_q      <= pend_d;
      pend_pos_q  <= pend_pos_d;
      cross_t_q   <= cross_t_d;
      cross_vld_q <= cross_vld_d;
      ovr_q       <= ovr_d;
      pin_vld_q   <= pin_vld_d;
      pin_q       <= pin_d;
      last_vld_q  <= last_vld_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      alt_mem_q[tbl_idx] <= s1_q.entry_altitude_m;
      id_mem_q[tbl_idx]  <= s1_q.entry_layer_id;
    end
  end

  // Output register: reload when the input register moves, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= res_fire;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_q.new_position      <= abds_pkg::PosW'(target);
      out_q.switched_layer_id <= id_mem_q[target];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_res_from_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |-> (s1_q.func == abds_pkg::FUNC_SAMPLE) && auto_en_q && s1_vld_q)
    else $error("result raised by an item that is not an enabled sample");

  a_cur_follows_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_fire |=> (cur_q == out_data_o.new_position) && out_valid_o)
    else $error("current band does not match the committed result");

  a_pend_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (CW'(pend_pos_q) != CW'(cur_q)))
    else $error("pending band equals the current band");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !s1_adv) |=> s1_vld_q && $stable(s1_q))
    else $error("input register lost an item while stalled");

endmodule

FILE: tb/sv/abds_checker.sv
`timescale 1ns / 1ps
module abds_checker #(
  parameter int unsigned MAX_LAYERS = abds_pkg::MaxLayersDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [abds_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [abds_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  abds_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  abds_pkg::out_t                out_data_i,
  output int                            fail_cnt_o,
  output int                            pending_o
);

  logic [abds_pkg::EntryAltW-1:0] layer_alt [MAX_LAYERS];
  logic [abds_pkg::LayerIdW-1:0]  layer_id  [MAX_LAYERS];
  logic [abds_pkg::PosW-1:0]      cur_pos;
  logic [abds_pkg::PosW-1:0]      pend_pos;
  logic                           pend_flag;
  logic [abds_pkg::TimeW-1:0]     cross_time;
  logic                           cross_ok;
  logic                           pin_active;
  int                             pinned_band;
  int                             last_band;

  logic                           auto_en;
  logic [abds_pkg::CountW-1:0]    layer_cnt;
  logic [abds_pkg::HoldW-1:0]     hold_s;

  abds_pkg::out_t                 switch_q[$];
  abds_pkg::out_t                 want;
  int                             fails;

  task automatic step_selector(input abds_pkg::in_t item);
    longint                     alt_dm;
    int                         n;
    int                         target;
    logic [abds_pkg::TimeW-1:0] elapsed;
    abds_pkg::out_t             sw;
    case (item.func)
      abds_pkg::FUNC_SAMPLE: begin
        if (!auto_en) return;
        if (!item.gps_alt_dm[abds_pkg::AltDmW-1]) alt_dm = item.gps_alt_dm;
        else if (!item.baro_alt_dm[abds_pkg::AltDmW-1]) alt_dm = item.baro_alt_dm;
        else return;
        n = (layer_cnt > MAX_LAYERS) ? MAX_LAYERS : layer_cnt;
        if (n < 2) return;
        // thresholds sit at the midpoint of neighbouring layers, in dm
        target = 0;
        for (int i = 0; i + 1 < n; i++) begin
          if (2 * alt_dm >= 10 * (longint'(layer_alt[i]) + longint'(layer_alt[i+1])))
            target = i + 1;
        end
        last_band = target;
        if (pin_active) begin
          if (pinned_band < 0) begin
            pinned_band = target;
            return;
          end
          if (target == pinned_band) return;
          pin_active = 1'b0;
        end
        if (target == cur_pos) begin
          pend_flag = 1'b0;
          return;
        end
        if (!pend_flag || pend_pos != target) begin
          pend_flag  = 1'b1;
          pend_pos   = target[abds_pkg::PosW-1:0];
          cross_time = item.now_seconds;
          cross_ok   = item.now_valid;
          return;
        end
        // a negative elapsed time keeps waiting
        if (item.now_valid && cross_ok) begin
          elapsed = item.now_seconds - cross_time;
          if (elapsed[abds_pkg::TimeW-1] || elapsed < hold_s) return;
        end
        pend_flag            = 1'b0;
        cur_pos              = target[abds_pkg::PosW-1:0];
        sw.new_position      = target[abds_pkg::PosW-1:0];
        sw.switched_layer_id = layer_id[target];
        switch_q             = {switch_q, sw};
      end
      abds_pkg::FUNC_STEP: begin
        pin_active  = 1'b1;
        pinned_band = last_band;
        pend_flag   = 1'b0;
      end
      abds_pkg::FUNC_SET_POS: begin
        cur_pos   = item.position;
        pend_flag = 1'b0;
      end
      default: begin
        if (item.position < MAX_LAYERS) begin
          layer_alt[item.position] = item.entry_altitude_m;
          layer_id[item.position]  = item.entry_layer_id;
          pend_flag   = 1'b0;
          pin_active  = 1'b0;
          pinned_band = -1;
          last_band   = -1;
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pos     = '0;
      pend_pos    = '0;
      pend_flag   = 1'b0;
      cross_time  = '0;
      cross_ok    = 1'b0;
      pin_active  = 1'b0;
      pinned_band = -1;
      last_band   = -1;
      auto_en     = 1'b0;
      layer_cnt   = '0;
      hold_s      = abds_pkg::HoldReset;
      fails       = 0;
      switch_q.delete();
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      // results leave before this edge's input can add one
      if (out_valid_i && !out_stall_i) begin
        if (switch_q.size() == 0) begin
          $error("unexpected switch: new_position %0d, switched_layer_id %0d",
                 out_data_i.new_position, out_data_i.switched_layer_id);
          fails++;
        end else begin
          want = switch_q.pop_front();
          if (out_data_i.new_position !== want.new_position) begin
            $error("new_position: expected %0d, actual %0d",
                   want.new_position, out_data_i.new_position);
            fails++;
          end
          if (out_data_i.switched_layer_id !== want.switched_layer_id) begin
            $error("switched_layer_id: expected %0d, actual %0d",
                   want.switched_layer_id, out_data_i.switched_layer_id);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          abds_pkg::CFG_AUTO_EN:   auto_en   = cfg_wdata_i[0];
          abds_pkg::CFG_LAYER_CNT: layer_cnt = cfg_wdata_i[abds_pkg::CountW-1:0];
          abds_pkg::CFG_HOLD:      hold_s    = cfg_wdata_i[abds_pkg::HoldW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) step_selector(in_data_i);
      pending_o  <= switch_q.size();
      fail_cnt_o <= fails;
    end
  end

endmodule

FILE: tb/sv/tb_altitude_band_dwell_selector.sv
`timescale 1ns / 1ps
module tb_altitude_band_dwell_selector;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [abds_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [abds_pkg::CfgDataW-1:0] cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  abds_pkg::in_t                 in_data;
  logic                          out_valid;
  logic                          out_stall;
  abds_pkg::out_t                out_data;
  int                            fail_cnt;
  int                            pending;

  logic                          quiet;
  int                            alt_walk;
  int                            hold_now;
  int                            cnt_now;
  int                            r;
  logic [abds_pkg::TimeW-1:0]    t_s;

  altitude_band_dwell_selector DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  abds_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 14);
  end

  function automatic int any_alt();
    return int'($urandom_range(0, 400000)) - 100000;
  endfunction

  function automatic abds_pkg::in_t sample_item(int gps, int baro,
                                                logic [abds_pkg::TimeW-1:0] t, logic ok);
    abds_pkg::in_t it;
    it.func             = abds_pkg::FUNC_SAMPLE;
    it.gps_alt_dm       = abds_pkg::AltDmW'(gps);
    it.baro_alt_dm      = abds_pkg::AltDmW'(baro);
    it.now_seconds      = t;
    it.now_valid        = ok;
    it.position         = abds_pkg::PosW'($urandom_range(0, 15));
    it.entry_altitude_m = abds_pkg::EntryAltW'($urandom_range(0, 20000));
    it.entry_layer_id   = abds_pkg::LayerIdW'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic abds_pkg::in_t op_item(abds_pkg::func_e f, int pos, int alt_m, int id);
    abds_pkg::in_t it;
    it                  = sample_item(any_alt(), any_alt(), $urandom(),
                                      $urandom_range(0, 1) != 0);
    it.func             = f;
    it.position         = abds_pkg::PosW'(pos);
    it.entry_altitude_m = abds_pkg::EntryAltW'(alt_m);
    it.entry_layer_id   = abds_pkg::LayerIdW'(id);
    return it;
  endfunction

  task automatic send_item(input abds_pkg::in_t item);
    while (!quiet && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every switch to drain, plus the pipeline depth
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic auto_on, int cnt, int hold);
    cfg_we    <= 1'b1;
    cfg_idx   <= abds_pkg::CFG_AUTO_EN;
    cfg_wdata <= abds_pkg::CfgDataW'(auto_on);
    @(posedge clk);
    cfg_idx   <= abds_pkg::CFG_LAYER_CNT;
    cfg_wdata <= abds_pkg::CfgDataW'(cnt);
    @(posedge clk);
    cfg_idx   <= abds_pkg::CFG_HOLD;
    cfg_wdata <= abds_pkg::CfgDataW'(hold);
    @(posedge clk);
    cfg_we    <= 1'b0;
    hold_now   = hold;
  endtask

  task automatic load_table(bit sorted);
    for (int i = 0; i < 16; i++) begin
      if (sorted)
        send_item(op_item(abds_pkg::FUNC_WRITE, i, i * 1200 + $urandom_range(0, 1000),
                          $urandom_range(0, 255)));
      else
        send_item(op_item(abds_pkg::FUNC_WRITE, i, $urandom_range(0, 20000),
                          $urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= abds_pkg::CFG_AUTO_EN;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    quiet     <= 1'b0;
    hold_now   = 20;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: auto off, no layers
    send_item(sample_item(1000, 1000, 32'd1, 1'b1));
    send_item(op_item(abds_pkg::FUNC_WRITE, 0, 0, 'h00));
    send_item(op_item(abds_pkg::FUNC_WRITE, 1, 100, 'h55));
    send_item(op_item(abds_pkg::FUNC_WRITE, 2, 500, 'hAA));
    send_item(op_item(abds_pkg::FUNC_WRITE, 3, 20000, 'hFF));
    // pin before any band is known, then move the position by hand
    send_item(op_item(abds_pkg::FUNC_STEP, 0, 0, 0));
    send_item(op_item(abds_pkg::FUNC_SET_POS, 2, 0, 0));
    settle();
    configure(1'b1, 1, 20);
    send_item(sample_item(1000, 1000, 32'd2, 1'b1));
    settle();
    configure(1'b1, 4, 20);
    send_item(sample_item(-1, -1, 32'd3, 1'b1));
    send_item(sample_item(-100000, 3500, 32'd100, 1'b1));
    send_item(sample_item(300000, 0, 32'd101, 1'b1));
    send_item(sample_item(300000, 0, 32'd110, 1'b1));
    send_item(sample_item(300000, 0, 32'd121, 1'b1));
    send_item(sample_item(0, 0, 32'd0, 1'b0));
    send_item(sample_item(0, 0, 32'd5, 1'b1));
    // dwell across the wrap of the seconds counter, and a negative elapsed time
    send_item(sample_item(600, 0, 32'hFFFF_FFFF, 1'b1));
    send_item(sample_item(600, 0, 32'd5, 1'b1));
    send_item(sample_item(600, 0, 32'h7FFF_FFFF, 1'b1));
    send_item(sample_item(600, 0, 32'd30, 1'b1));
    send_item(op_item(abds_pkg::FUNC_STEP, 0, 0, 0));
    send_item(sample_item(600, 0, 32'd35, 1'b1));
    send_item(sample_item(3500, 0, 32'd40, 1'b1));
    send_item(sample_item(3500, 0, 32'd41, 1'b0));
    send_item(op_item(abds_pkg::FUNC_WRITE, 0, 0, 'h11));

    alt_walk = 0;
    t_s      = '0;
    for (int ph = 0; ph < 12; ph++) begin
      settle();
      case (ph)
        0: configure(1'b1, 16, 0);
        1: configure(1'b1, 31, 255);
        2: configure(1'b1, 2, $urandom_range(0, 30));
        3: configure(1'b0, 16, $urandom_range(0, 255));
        4: configure(1'b1, 0, 10);
        default: begin
          cnt_now = (ph == 8) ? 17 : $urandom_range(2, 16);
          configure(1'b1, cnt_now, $urandom_range(0, 255));
        end
      endcase
      quiet <= (ph == 6);
      if (ph == 0 || $urandom_range(0, 2) == 0) load_table($urandom_range(0, 3) != 0);
      for (int k = 0; k < 87; k++) begin
        r = $urandom_range(0, 99);
        if (r < 78) begin
          // a flight: drift in altitude, time moves forward in steps scaled to the dwell time
          if ($urandom_range(0, 99) < 5) alt_walk = $urandom_range(0, 300000);
          else alt_walk += int'($urandom_range(0, 5000)) - 2500;
          if (alt_walk < 0) alt_walk = 0;
          if (alt_walk > 300000) alt_walk = 300000;
          if ($urandom_range(0, 99) < 3) t_s = $urandom();
          else t_s += $urandom_range(0, hold_now / 3 + 4);
          r = $urandom_range(0, 99);
          if (r < 70)
            send_item(sample_item(alt_walk, any_alt(), t_s, $urandom_range(0, 9) != 0));
          else if (r < 94)
            send_item(sample_item(-int'($urandom_range(1, 100000)), alt_walk, t_s,
                                  $urandom_range(0, 9) != 0));
          else
            send_item(sample_item(-int'($urandom_range(1, 100000)),
                                  -int'($urandom_range(1, 100000)), t_s, 1'b1));
        end else if (r < 84) begin
          send_item(op_item(abds_pkg::FUNC_STEP, $urandom_range(0, 15), 0, 0));
        end else if (r < 90) begin
          send_item(op_item(abds_pkg::FUNC_SET_POS, $urandom_range(0, 15), 0, 0));
        end else if (r < 95) begin
          send_item(op_item(abds_pkg::FUNC_WRITE, $urandom_range(0, 15),
                            $urandom_range(0, 20000), $urandom_range(0, 255)));
        end else begin
          send_item(sample_item(any_alt(), any_alt(), $urandom(),
                                $urandom_range(0, 1) != 0));
        end
      end
    end

    quiet <= 1'b0;
    settle();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/abds_pkg.sv
rtl/core/altitude_band_dwell_selector.sv
tb/sv/abds_checker.sv
tb/sv/tb_altitude_band_dwell_selector.sv
